### rtl/tad_pkg.sv
// ----------------------------------------------------------------------------
// tad_pkg
// Shared constants, widths and the sequencer state type of the averaging
// temperature display.
// ----------------------------------------------------------------------------
`default_nettype none

package tad_pkg;

  // Number of samples averaged
  localparam int WINDOW   = 10;
  localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W    = $clog2(WINDOW + 1);

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 16;
  localparam int SHOWN_W  = 13;
  localparam int DIGIT_W  = 4;
  localparam int NUM_DIG  = 4;
  localparam int BIT_W    = $clog2(SUM_W);
  localparam int DIG_IDX_W = $clog2(NUM_DIG);

  // Fahrenheit conversion: x/5 as (x * ceil(2^18/5)) >> 18, exact below 2^16
  localparam int                 PROD5_W  = 32;
  localparam int                 SHIFT5   = 18;
  localparam logic [SUM_W-1:0]   RECIP5   = 16'd52429;
  localparam logic [SHOWN_W-1:0] F_OFFSET = 13'd320;

  // Decimal digit step: x/10 as (x * ceil(2^16/10)) >> 16, exact below 2^14
  localparam int                 PROD10_W = 2 * SHOWN_W;
  localparam logic [SHOWN_W-1:0] RECIP10  = 13'd6554;

  // Unit symbol codes
  localparam logic [DIGIT_W-1:0] SYM_CELSIUS    = 4'd11;
  localparam logic [DIGIT_W-1:0] SYM_FAHRENHEIT = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_CONV,
    ST_FIX,
    ST_DIGIT,
    ST_DONE
  } tad_state_t;

endpackage

`default_nettype wire

### rtl/tad_ram.sv
// ----------------------------------------------------------------------------
// tad_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                         wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/temperature_average_display_core.sv
// ----------------------------------------------------------------------------
// temperature_average_display_core
// Moving average of temperature samples with Celsius/Fahrenheit display digits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_sample_tenths) takes one reading in
//   tenths of a degree Celsius per transaction. The block averages the newest
//   WINDOW readings (fewer while the window is still filling), converts to
//   Fahrenheit tenths when cfg_wdata was written as 1, and returns one result
//   transaction on the output channel: value, four decimal digits, unit code.
//   From input acceptance to out_valid a sample passes through these steps:
//   the swap of the sample into the sum and the store, the bit-serial
//   sum/count divider, two conversion steps, four decimal digit steps and
//   the load of the output register. The block takes no new sample before
//   it is through with the last one: in_stall is high while a sample is in work.
//   Results sit in an output register; the next sample is taken while a
//   result still waits, and a finished result waits in the last step until
//   the output register is free. The sample store is written once per sample
//   and its read data is used once, in the swap step.
//   Reset (rst_n low, synchronous) empties the window, clears the running sum,
//   slot and fill count, selects Celsius and drops any pending result.
//   cfg_we writes the mode; write it only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module temperature_average_display_core
  import tad_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [SAMPLE_W-1:0] in_sample_tenths,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [SHOWN_W-1:0]       out_shown_value,
  output logic [DIGIT_W-1:0]       out_digit_thousands,
  output logic [DIGIT_W-1:0]       out_digit_hundreds,
  output logic [DIGIT_W-1:0]       out_digit_tens,
  output logic [DIGIT_W-1:0]       out_digit_ones,
  output logic [DIGIT_W-1:0]       out_unit_symbol
);

  // Control state
  tad_state_t            state_r, state_nxt;
  logic                  fahr_r, fahr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [WINDOW-1:0]     vld_r, vld_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [BIT_W-1:0]      bit_r, bit_nxt;
  logic [DIG_IDX_W-1:0]  idx_r, idx_nxt;

  // Datapath
  logic [SAMPLE_W-1:0]   sample_r, sample_nxt;
  logic [SUM_W-1:0]      div_r, div_nxt;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic [PROD5_W-1:0]    prod_r, prod_nxt;
  logic [SHOWN_W-1:0]    shown_r, shown_nxt;
  logic [SHOWN_W-1:0]    work_r, work_nxt;
  logic [DIGIT_W-1:0]    dig_r [NUM_DIG];
  logic [DIGIT_W-1:0]    dig_nxt [NUM_DIG];

  // Output register
  logic [SHOWN_W-1:0]    o_shown_r, o_shown_nxt;
  logic [DIGIT_W-1:0]    o_dig_r [NUM_DIG];
  logic [DIGIT_W-1:0]    o_dig_nxt [NUM_DIG];
  logic [DIGIT_W-1:0]    o_sym_r, o_sym_nxt;

  // Sample store
  logic                  ram_we;
  logic [SAMPLE_W-1:0]   ram_rd_data;

  // Scratch
  logic [SAMPLE_W-1:0]   old_sample;
  logic [CNT_W:0]        trial;
  logic                  qbit;
  logic [SUM_W-1:0]      times9;
  logic [PROD10_W-1:0]   prod10;
  logic [SHOWN_W-1:0]    quot10;
  logic [SHOWN_W-1:0]    quot10_x10;

  tad_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (slot_r),
    .wr_data (sample_r),
    .rd_addr (slot_r),
    .rd_data (ram_rd_data)
  );

  // Sequencer: next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    fahr_nxt      = cfg_we ? cfg_wdata : fahr_r;
    out_valid_nxt = out_valid_r;
    vld_nxt       = vld_r;
    sum_nxt       = sum_r;
    slot_nxt      = slot_r;
    cnt_nxt       = cnt_r;
    bit_nxt       = bit_r;
    idx_nxt       = idx_r;
    sample_nxt    = sample_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    prod_nxt      = prod_r;
    shown_nxt     = shown_r;
    work_nxt      = work_r;
    dig_nxt       = dig_r;
    o_shown_nxt   = o_shown_r;
    o_dig_nxt     = o_dig_r;
    o_sym_nxt     = o_sym_r;
    ram_we        = 1'b0;
    in_stall      = (state_r != ST_IDLE);

    old_sample = vld_r[slot_r] ? ram_rd_data : '0;
    trial      = {rem_r, div_r[SUM_W-1]};
    qbit       = (trial >= {1'b0, cnt_r});
    times9     = {1'b0, div_r[SAMPLE_W-1:0], 3'b000} + SUM_W'(div_r[SAMPLE_W-1:0]);
    prod10     = PROD10_W'(work_r) * PROD10_W'(RECIP10);
    quot10     = SHOWN_W'(prod10[PROD10_W-1:16]);
    quot10_x10 = SHOWN_W'({quot10, 3'b000}) + SHOWN_W'({quot10, 1'b0});

    // Drop the result once the receiver takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        // Take a sample and read the slot it replaces
        if (in_valid) begin
          sample_nxt = in_sample_tenths;
          state_nxt  = ST_READ;
        end
      end
      ST_READ: begin
        // Swap the oldest sample out of the sum and store the new one
        sum_nxt        = sum_r - SUM_W'(old_sample) + SUM_W'(sample_r);
        ram_we         = 1'b1;
        vld_nxt[slot_r] = 1'b1;
        slot_nxt       = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
        cnt_nxt        = (cnt_r >= CNT_W'(WINDOW)) ? CNT_W'(WINDOW) : cnt_r + 1'b1;
        div_nxt        = sum_nxt;
        rem_nxt        = '0;
        bit_nxt        = BIT_W'(SUM_W - 1);
        state_nxt      = ST_DIV;
      end
      ST_DIV: begin
        // One restoring divide step; quotient bits shift in behind the dividend
        rem_nxt = qbit ? CNT_W'(trial - {1'b0, cnt_r}) : CNT_W'(trial);
        div_nxt = {div_r[SUM_W-2:0], qbit};
        bit_nxt = bit_r - 1'b1;
        if (bit_r == '0) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        // Average times 9, then times the reciprocal of 5
        prod_nxt  = PROD5_W'(times9) * PROD5_W'(RECIP5);
        state_nxt = ST_FIX;
      end
      ST_FIX: begin
        // Pick Celsius or Fahrenheit tenths
        shown_nxt = fahr_r ? SHOWN_W'(prod_r[PROD5_W-1:SHIFT5]) + F_OFFSET
                           : SHOWN_W'(div_r[SAMPLE_W-1:0]);
        work_nxt  = shown_nxt;
        idx_nxt   = '0;
        state_nxt = ST_DIGIT;
      end
      ST_DIGIT: begin
        // Peel off one decimal digit, least significant first
        dig_nxt[idx_r] = DIGIT_W'(work_r - quot10_x10);
        work_nxt       = quot10;
        idx_nxt        = idx_r + 1'b1;
        if (idx_r == DIG_IDX_W'(NUM_DIG - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          o_shown_nxt   = shown_r;
          o_dig_nxt     = dig_r;
          o_sym_nxt     = fahr_r ? SYM_FAHRENHEIT : SYM_CELSIUS;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fahr_r      <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      sum_r       <= '0;
      slot_r      <= '0;
      cnt_r       <= '0;
      bit_r       <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      fahr_r      <= fahr_nxt;
      out_valid_r <= out_valid_nxt;
      vld_r       <= vld_nxt;
      sum_r       <= sum_nxt;
      slot_r      <= slot_nxt;
      cnt_r       <= cnt_nxt;
      bit_r       <= bit_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sample_r  <= sample_nxt;
    div_r     <= div_nxt;
    rem_r     <= rem_nxt;
    prod_r    <= prod_nxt;
    shown_r   <= shown_nxt;
    work_r    <= work_nxt;
    dig_r     <= dig_nxt;
    o_shown_r <= o_shown_nxt;
    o_dig_r   <= o_dig_nxt;
    o_sym_r   <= o_sym_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_shown_value     = o_shown_r;
  assign out_digit_ones      = o_dig_r[0];
  assign out_digit_tens      = o_dig_r[1];
  assign out_digit_hundreds  = o_dig_r[2];
  assign out_digit_thousands = o_dig_r[3];
  assign out_unit_symbol     = o_sym_r;

endmodule

`default_nettype wire

### rtl/tad_checker.sv
// ----------------------------------------------------------------------------
// tad_checker
// Port-level checks of the averaging temperature display, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module tad_checker
  import tad_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [SHOWN_W-1:0]  out_shown_value,
  input wire logic [DIGIT_W-1:0]  out_digit_thousands,
  input wire logic [DIGIT_W-1:0]  out_digit_hundreds,
  input wire logic [DIGIT_W-1:0]  out_digit_tens,
  input wire logic [DIGIT_W-1:0]  out_digit_ones,
  input wire logic [DIGIT_W-1:0]  out_unit_symbol
);

  // No result straight after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A stalled result stays offered
  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn under stall");

  // A stalled result keeps its value
  a_value_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_shown_value) && $stable(out_unit_symbol))
    else $error("result changed under stall");

  // Digits spell the value
  a_digits_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 14'(out_shown_value) ==
      14'(out_digit_thousands) * 14'd1000 + 14'(out_digit_hundreds) * 14'd100
      + 14'(out_digit_tens) * 14'd10 + 14'(out_digit_ones))
    else $error("digits disagree with value");

  // Unit code is one of the two symbols
  a_unit_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_unit_symbol == SYM_CELSIUS || out_unit_symbol == SYM_FAHRENHEIT)
    else $error("bad unit symbol");

endmodule

bind temperature_average_display_core tad_checker u_tad_checker (.*);

`default_nettype wire
